// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that prop holds in the same cycle whenever cond holds.
`define VST_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("vst assertion failed");

// Checks that prop holds in the cycle after cond holds.
`define VST_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("vst assertion failed");

`endif

// ===== sv/vst_pkg.sv =====
`default_nettype none

package vst_pkg;

    localparam int SAMPLE_BITS   = 32;
    localparam int PROB_BITS     = 16;
    localparam int MS_BITS       = 28;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 32;
    localparam int OUT_DATA_BITS = 2 * MS_BITS;
    localparam int MS_PER_S      = 1000;

    localparam int DEF_WINDOW_SAMPLES     = 512;
    localparam int DEF_SAMPLE_RATE        = 16000;
    localparam int DEF_MAX_SPEECH_SILENCE = 1568;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [MS_BITS-1:0]     MS_MAX     = '1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD   = 4'd0,
        REG_DEAD_BAND   = 4'd1,
        REG_MIN_SILENCE = 4'd2,
        REG_MIN_SPEECH  = 4'd3,
        REG_MAX_SPEECH  = 4'd4,
        REG_PAD_BEFORE  = 4'd5,
        REG_PAD_AFTER   = 4'd6,
        REG_CLIP_LENGTH = 4'd7
    } vst_reg_t;

    typedef enum logic {
        FUNC_WINDOW = 1'b0,
        FUNC_END    = 1'b1
    } vst_func_t;

    typedef enum logic {
        ST_SILENCE = 1'b0,
        ST_SPEECH  = 1'b1
    } vst_state_t;

    typedef struct packed {
        logic [PROB_BITS-1:0]   threshold;
        logic [PROB_BITS-1:0]   dead_band;
        logic [SAMPLE_BITS-1:0] min_silence;
        logic [SAMPLE_BITS-1:0] min_speech;
        logic [SAMPLE_BITS-1:0] max_speech;
        logic [15:0]            pad_before;
        logic [15:0]            pad_after;
        logic [SAMPLE_BITS-1:0] clip_length;
    } vst_cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] start_pos;
        logic [SAMPLE_BITS-1:0] end_pos;
    } vst_seg_t;

endpackage

`default_nettype wire

// ===== sv/vad_segment_tracker_top.sv =====
// Pipeline: a window or end item passes through the input register, segment decision, padding,
// scaling multiply, reciprocal partial products and reciprocal sum before its result appears on m_axis.
// Throughput: one item per cycle; each stage holds one item and stalls only on m_axis_tready.
// Reset: rst_n is asynchronous and active low; it clears the tracker state and the pipeline
// and restores the register defaults.
`default_nettype none

module vad_segment_tracker_top
    import vst_pkg::*;
#(
    parameter int WINDOW_SAMPLES     = DEF_WINDOW_SAMPLES,
    parameter int SAMPLE_RATE        = DEF_SAMPLE_RATE,
    parameter int MAX_SPEECH_SILENCE = DEF_MAX_SPEECH_SILENCE
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [PROB_BITS-1:0]     s_axis_tdata,  // [15:0] speech_prob
    input  wire logic [0:0]               s_axis_tuser,  // [0] func
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0]      m_axis_tdata,  // [27:0] start_ms, [55:28] end_ms
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    vst_cfg_t           cfg;
    logic               seg_valid;
    logic               seg_ready;
    vst_seg_t           seg;
    logic [MS_BITS-1:0] start_ms;
    logic [MS_BITS-1:0] end_ms;

    vst_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vst_tracker #(
        .WINDOW_SAMPLES     (WINDOW_SAMPLES),
        .MAX_SPEECH_SILENCE (MAX_SPEECH_SILENCE)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser[0]),
        .in_prob   (s_axis_tdata),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    vst_ms_conv #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_ms_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (seg_valid),
        .in_ready     (seg_ready),
        .in_seg       (seg),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_start_ms (start_ms),
        .out_end_ms   (end_ms)
    );

    assign m_axis_tdata = {end_ms, start_ms};

endmodule

`default_nettype wire

// ===== sv/vst_cfg_regs.sv =====
`default_nettype none

module vst_cfg_regs
    import vst_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output vst_cfg_t                      cfg
);

    vst_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= 16'd16384;
            cfg_reg.dead_band   <= 16'd4915;
            cfg_reg.min_silence <= 32'd1600;
            cfg_reg.min_speech  <= 32'd4000;
            cfg_reg.max_speech  <= SAMPLE_MAX;
            cfg_reg.pad_before  <= 16'd480;
            cfg_reg.pad_after   <= 16'd0;
            cfg_reg.clip_length <= 32'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_THRESHOLD:   cfg_reg.threshold   <= cfg_data[PROB_BITS-1:0];
                REG_DEAD_BAND:   cfg_reg.dead_band   <= cfg_data[PROB_BITS-1:0];
                REG_MIN_SILENCE: cfg_reg.min_silence <= cfg_data[SAMPLE_BITS-1:0];
                REG_MIN_SPEECH:  cfg_reg.min_speech  <= cfg_data[SAMPLE_BITS-1:0];
                REG_MAX_SPEECH:  cfg_reg.max_speech  <= cfg_data[SAMPLE_BITS-1:0];
                REG_PAD_BEFORE:  cfg_reg.pad_before  <= cfg_data[15:0];
                REG_PAD_AFTER:   cfg_reg.pad_after   <= cfg_data[15:0];
                REG_CLIP_LENGTH: cfg_reg.clip_length <= cfg_data[SAMPLE_BITS-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/vst_tracker.sv =====
`default_nettype none

module vst_tracker
    import vst_pkg::*;
#(
    parameter int WINDOW_SAMPLES     = DEF_WINDOW_SAMPLES,
    parameter int MAX_SPEECH_SILENCE = DEF_MAX_SPEECH_SILENCE
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  vst_cfg_t                  cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_func,
    input  wire logic [PROB_BITS-1:0] in_prob,
    output logic                      seg_valid,
    input  wire logic                 seg_ready,
    output vst_seg_t                  seg
);

    localparam logic [SAMPLE_BITS-1:0] WIN       = SAMPLE_BITS'(WINDOW_SAMPLES);
    localparam logic [SAMPLE_BITS-1:0] POS_LIMIT = SAMPLE_MAX - WIN;
    localparam logic [SAMPLE_BITS-1:0] HANGOVER  = SAMPLE_BITS'(MAX_SPEECH_SILENCE);

    logic                   v0_reg;
    vst_func_t              func_reg;
    logic [PROB_BITS-1:0]   prob_reg;
    logic                   v1_reg;
    vst_seg_t               seg_reg;

    vst_state_t             state_reg, state_next;
    logic [SAMPLE_BITS-1:0] pos_reg, pos_next;
    logic [SAMPLE_BITS-1:0] tent_reg, tent_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [SAMPLE_BITS-1:0] nstart_reg, nstart_next;
    logic [SAMPLE_BITS-1:0] sstart_reg, sstart_next;

    logic                   consume;
    logic                   triggered;
    logic [SAMPLE_BITS-1:0] pos_inc;
    logic [SAMPLE_BITS-1:0] win_start;
    logic                   is_speech;
    logic                   above_low;
    logic [SAMPLE_BITS:0]   run_diff;
    logic                   split;
    logic [SAMPLE_BITS-1:0] tent_eff;
    logic [SAMPLE_BITS-1:0] gap;
    logic [SAMPLE_BITS:0]   len_diff;
    logic                   long_enough;
    logic                   has_prev;
    logic                   next_behind;
    logic                   emit;
    logic [SAMPLE_BITS-1:0] emit_end;

    assign in_ready  = !v0_reg || seg_ready;
    assign consume   = v0_reg && seg_ready;
    assign seg_valid = v1_reg;
    assign seg       = seg_reg;

    assign triggered   = (state_reg == ST_SPEECH);
    assign pos_inc     = (pos_reg > POS_LIMIT) ? SAMPLE_MAX : pos_reg + WIN;
    assign win_start   = (pos_inc >= WIN) ? pos_inc - WIN : '0;
    assign is_speech   = (prob_reg >= cfg.threshold);
    assign above_low   = (({1'b0, prob_reg} + {1'b0, cfg.dead_band}) >= {1'b0, cfg.threshold});
    assign run_diff    = {1'b0, pos_inc} - {1'b0, sstart_reg};
    assign split       = triggered && !run_diff[SAMPLE_BITS]
                         && (run_diff[SAMPLE_BITS-1:0] > cfg.max_speech);
    assign tent_eff    = (tent_reg == '0) ? pos_inc : tent_reg;
    assign gap         = (pos_inc >= tent_eff) ? pos_inc - tent_eff : '0;
    assign len_diff    = {1'b0, tent_eff} - {1'b0, sstart_reg};
    assign long_enough = !len_diff[SAMPLE_BITS] && (len_diff[SAMPLE_BITS-1:0] > cfg.min_speech);
    assign has_prev    = (prev_reg != '0);
    assign next_behind = (nstart_reg < prev_reg);

    always_comb
    begin
        state_next = state_reg;
        if (consume)
        begin
            priority if (func_reg == FUNC_END)
                state_next = ST_SILENCE;
            else if (is_speech)
                state_next = ST_SPEECH;
            else if (split)
            begin
                if (!has_prev || next_behind)
                    state_next = ST_SILENCE;
            end
            else if (!above_low && triggered && (gap >= cfg.min_silence))
                state_next = ST_SILENCE;
            else
                state_next = state_reg;
        end
    end

    always_comb
    begin
        pos_next    = pos_reg;
        tent_next   = tent_reg;
        prev_next   = prev_reg;
        nstart_next = nstart_reg;
        sstart_next = sstart_reg;
        emit        = 1'b0;
        emit_end    = tent_eff;
        if (consume)
        begin
            if (func_reg == FUNC_END)
            begin
                emit        = triggered;
                emit_end    = cfg.clip_length;
                pos_next    = '0;
                sstart_next = '0;
                tent_next   = '0;
                prev_next   = '0;
                nstart_next = '0;
            end
            else
            begin
                pos_next = pos_inc;
                priority if (is_speech)
                begin
                    if (tent_reg != '0)
                    begin
                        tent_next = '0;
                        if (next_behind)
                            nstart_next = win_start;
                    end
                    if (!triggered)
                        sstart_next = win_start;
                end
                else if (split)
                begin
                    emit = 1'b1;
                    if (has_prev)
                    begin
                        emit_end    = prev_reg;
                        sstart_next = next_behind ? '0 : nstart_reg;
                    end
                    else
                    begin
                        emit_end    = pos_inc;
                        sstart_next = '0;
                    end
                    tent_next   = '0;
                    prev_next   = '0;
                    nstart_next = '0;
                end
                else if (!above_low && triggered)
                begin
                    tent_next = tent_eff;
                    if (gap > HANGOVER)
                        prev_next = tent_eff;
                    if (gap >= cfg.min_silence)
                    begin
                        emit        = long_enough;
                        emit_end    = tent_eff;
                        sstart_next = '0;
                        tent_next   = '0;
                        prev_next   = '0;
                        nstart_next = '0;
                    end
                end
                else
                    emit = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            state_reg  <= ST_SILENCE;
            pos_reg    <= '0;
            tent_reg   <= '0;
            prev_reg   <= '0;
            nstart_reg <= '0;
            sstart_reg <= '0;
        end
        else
        begin
            if (in_ready)
                v0_reg <= in_valid;
            if (seg_ready)
                v1_reg <= v0_reg && emit;
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            tent_reg   <= tent_next;
            prev_reg   <= prev_next;
            nstart_reg <= nstart_next;
            sstart_reg <= sstart_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            func_reg <= vst_func_t'(in_func);
            prob_reg <= in_prob;
        end
        if (consume && emit)
        begin
            seg_reg.start_pos <= sstart_reg;
            seg_reg.end_pos   <= emit_end;
        end
    end

endmodule

`default_nettype wire

// ===== sv/vst_ms_conv.sv =====
`default_nettype none

module vst_ms_conv
    import vst_pkg::*;
#(
    parameter int SAMPLE_RATE = DEF_SAMPLE_RATE
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  vst_cfg_t                cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  vst_seg_t                in_seg,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [MS_BITS-1:0]      out_start_ms,
    output logic [MS_BITS-1:0]      out_end_ms
);

    // Division by the sample rate is a multiplication by a rounded-up
    // reciprocal, exact for every scaled sample count.
    localparam int SCALE_BITS  = $clog2(MS_PER_S + 1);
    localparam int X_BITS      = SAMPLE_BITS + SCALE_BITS;
    localparam int RATE_BITS   = $clog2(SAMPLE_RATE + 1);
    localparam int SHIFT       = X_BITS + RATE_BITS;
    localparam int RECIP_BITS  = X_BITS + 2;
    localparam int LO_BITS     = RECIP_BITS / 2;
    localparam int HI_BITS     = RECIP_BITS - LO_BITS;
    localparam int PP_BITS     = X_BITS + HI_BITS;
    localparam int FULL_BITS   = X_BITS + RECIP_BITS;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam logic [LO_BITS-1:0]    RECIP_LO = RECIP[LO_BITS-1:0];
    localparam logic [HI_BITS-1:0]    RECIP_HI = RECIP[RECIP_BITS-1:LO_BITS];
    localparam logic [SCALE_BITS-1:0] SCALE    = SCALE_BITS'(MS_PER_S);

    logic                   v_pad_reg, v_mul_reg, v_pp_reg, v_out_reg;
    logic                   r_pad, r_mul, r_pp, r_out;

    logic [SAMPLE_BITS-1:0] pad_reg  [2];
    logic [SAMPLE_BITS-1:0] pad_next [2];
    logic [X_BITS-1:0]      x_reg    [2];
    logic [X_BITS-1:0]      x_next   [2];
    logic [PP_BITS-1:0]     plo_reg  [2];
    logic [PP_BITS-1:0]     plo_next [2];
    logic [PP_BITS-1:0]     phi_reg  [2];
    logic [PP_BITS-1:0]     phi_next [2];
    logic [MS_BITS-1:0]     ms_reg   [2];
    logic [MS_BITS-1:0]     ms_next  [2];

    logic [SAMPLE_BITS:0]   end_sum;
    logic [FULL_BITS-1:0]   full     [2];
    logic [FULL_BITS-1:0]   quo      [2];

    assign r_out    = !v_out_reg || out_ready;
    assign r_pp     = !v_pp_reg  || r_out;
    assign r_mul    = !v_mul_reg || r_pp;
    assign r_pad    = !v_pad_reg || r_mul;
    assign in_ready = r_pad;

    assign out_valid    = v_out_reg;
    assign out_start_ms = ms_reg[0];
    assign out_end_ms   = ms_reg[1];

    always_comb
    begin
        end_sum     = {1'b0, in_seg.end_pos} + (SAMPLE_BITS + 1)'(cfg.pad_after);
        pad_next[0] = (in_seg.start_pos > SAMPLE_BITS'(cfg.pad_before))
                      ? in_seg.start_pos - SAMPLE_BITS'(cfg.pad_before) : '0;
        pad_next[1] = (end_sum > {1'b0, cfg.clip_length})
                      ? cfg.clip_length : end_sum[SAMPLE_BITS-1:0];
        for (int i = 0; i < 2; i++)
        begin
            x_next[i]   = X_BITS'(pad_reg[i]) * X_BITS'(SCALE);
            plo_next[i] = PP_BITS'(x_reg[i]) * PP_BITS'(RECIP_LO);
            phi_next[i] = PP_BITS'(x_reg[i]) * PP_BITS'(RECIP_HI);
            full[i]     = (FULL_BITS'(phi_reg[i]) << LO_BITS) + FULL_BITS'(plo_reg[i]);
            quo[i]      = full[i] >> SHIFT;
            ms_next[i]  = (quo[i] > FULL_BITS'(MS_MAX)) ? MS_MAX : quo[i][MS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pad_reg <= 1'b0;
            v_mul_reg <= 1'b0;
            v_pp_reg  <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            if (r_pad)
                v_pad_reg <= in_valid;
            if (r_mul)
                v_mul_reg <= v_pad_reg;
            if (r_pp)
                v_pp_reg <= v_mul_reg;
            if (r_out)
                v_out_reg <= v_pp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 2; i++)
        begin
            if (in_valid && r_pad)
                pad_reg[i] <= pad_next[i];
            if (v_pad_reg && r_mul)
                x_reg[i] <= x_next[i];
            if (v_mul_reg && r_pp)
            begin
                plo_reg[i] <= plo_next[i];
                phi_reg[i] <= phi_next[i];
            end
            if (v_pp_reg && r_out)
                ms_reg[i] <= ms_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== sv/vst_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module vst_checker
    import vst_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_axis_tready,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input wire logic                     cfg_valid,
    input wire logic                     cfg_ready
);

    // A stalled result stays put until it is taken.
    `VST_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // With the output free, every stage can move, so the input side must be ready.
    `VST_ASSERT_NOW(a_in_ready_free, !m_axis_tvalid || m_axis_tready, s_axis_tready)

    // Register writes are never held off.
    `VST_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind vad_segment_tracker_top vst_checker u_vst_checker (.*);

`default_nettype wire

// ===== test/vad_segment_tracker_top_test.sv =====
`default_nettype none

module vad_segment_tracker_top_test;
    import vst_pkg::*;

    localparam int WINDOW_SAMPLES     = DEF_WINDOW_SAMPLES;
    localparam int SAMPLE_RATE        = DEF_SAMPLE_RATE;
    localparam int MAX_SPEECH_SILENCE = DEF_MAX_SPEECH_SILENCE;
    localparam int SETTLE_CYCLES      = 12;
    localparam int RUN_LIMIT          = 5_000_000;
    localparam logic [PROB_BITS-1:0] PROB_ONE = 16'd32768;

    typedef struct {
        bit [MS_BITS-1:0] start_ms;
        bit [MS_BITS-1:0] end_ms;
    } segment_ms_t;

    typedef enum {
        PROB_SPEECH,
        PROB_DEAD,
        PROB_QUIET,
        PROB_ANY
    } prob_class_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [PROB_BITS-1:0]     s_axis_tdata = '0;
    logic [0:0]               s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    bit [PROB_BITS-1:0]   cur_threshold;
    bit [PROB_BITS-1:0]   cur_dead_band;
    bit [SAMPLE_BITS-1:0] cur_min_silence;
    bit [SAMPLE_BITS-1:0] cur_min_speech;
    bit [SAMPLE_BITS-1:0] cur_max_speech;
    bit [15:0]            cur_pad_before;
    bit [15:0]            cur_pad_after;
    bit [SAMPLE_BITS-1:0] cur_clip_length;

    bit                   in_segment;
    bit [SAMPLE_BITS-1:0] sample_count;
    bit [SAMPLE_BITS-1:0] hangover_end;
    bit [SAMPLE_BITS-1:0] split_end;
    bit [SAMPLE_BITS-1:0] split_start;
    bit [SAMPLE_BITS-1:0] seg_begin;

    segment_ms_t segments_due[$];
    int          mismatches = 0;
    int          src_gap_max = 0;
    int          sink_gap_max = 0;
    int          sink_wait = 0;
    int          sink_hold_cycles = 0;

    vad_segment_tracker_top #(
        .WINDOW_SAMPLES     (WINDOW_SAMPLES),
        .SAMPLE_RATE        (SAMPLE_RATE),
        .MAX_SPEECH_SILENCE (MAX_SPEECH_SILENCE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void forget_split();
        split_end = '0;
        split_start = '0;
        hangover_end = '0;
    endfunction

    function automatic void clear_tracker();
        in_segment = 1'b0;
        sample_count = '0;
        seg_begin = '0;
        forget_split();
    endfunction

    function automatic void restore_defaults();
        cur_threshold = 16'd16384;
        cur_dead_band = 16'd4915;
        cur_min_silence = 32'd1600;
        cur_min_speech = 32'd4000;
        cur_max_speech = SAMPLE_MAX;
        cur_pad_before = 16'd480;
        cur_pad_after = 16'd0;
        cur_clip_length = '0;
        clear_tracker();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] v);
        case (vst_reg_t'(idx))
            REG_THRESHOLD:   cur_threshold = v[15:0];
            REG_DEAD_BAND:   cur_dead_band = v[15:0];
            REG_MIN_SILENCE: cur_min_silence = v;
            REG_MIN_SPEECH:  cur_min_speech = v;
            REG_MAX_SPEECH:  cur_max_speech = v;
            REG_PAD_BEFORE:  cur_pad_before = v[15:0];
            REG_PAD_AFTER:   cur_pad_after = v[15:0];
            REG_CLIP_LENGTH: cur_clip_length = v;
            default:         ;
        endcase
    endfunction

    function automatic bit [MS_BITS-1:0] samples_to_ms(longint unsigned n);
        longint unsigned ms;
        ms = n * MS_PER_S / SAMPLE_RATE;
        return (ms > MS_MAX) ? MS_MAX : ms[MS_BITS-1:0];
    endfunction

    function automatic void push_segment(bit [SAMPLE_BITS-1:0] s, bit [SAMPLE_BITS-1:0] e);
        segment_ms_t     seg;
        longint unsigned first_sample;
        longint unsigned last_sample;
        first_sample = (s > cur_pad_before) ? {32'd0, s} - {48'd0, cur_pad_before} : 0;
        last_sample = {32'd0, e} + {48'd0, cur_pad_after};
        if (last_sample > {32'd0, cur_clip_length})
        begin
            last_sample = {32'd0, cur_clip_length};
        end
        seg.start_ms = samples_to_ms(first_sample);
        seg.end_ms = samples_to_ms(last_sample);
        segments_due.insert(segments_due.size(), seg);
    endfunction

    function automatic void predict_item(vst_func_t f, bit [PROB_BITS-1:0] p);
        longint               prob;
        longint               floor_q15;
        longint               span;
        bit [SAMPLE_BITS-1:0] win_start;
        bit [SAMPLE_BITS-1:0] gap;
        prob = longint'({48'd0, p});
        floor_q15 = longint'({48'd0, cur_threshold}) - longint'({48'd0, cur_dead_band});
        if (f == FUNC_END)
        begin
            if (in_segment)
            begin
                push_segment(seg_begin, cur_clip_length);
            end
            clear_tracker();
            return;
        end
        if (sample_count > SAMPLE_MAX - WINDOW_SAMPLES)
        begin
            sample_count = SAMPLE_MAX;
        end
        else
        begin
            sample_count = sample_count + WINDOW_SAMPLES;
        end
        win_start = (sample_count >= WINDOW_SAMPLES) ? sample_count - WINDOW_SAMPLES : '0;

        if (prob >= longint'({48'd0, cur_threshold}))
        begin
            if (hangover_end != 0)
            begin
                hangover_end = '0;
                if (split_start < split_end)
                begin
                    split_start = win_start;
                end
            end
            if (!in_segment)
            begin
                in_segment = 1'b1;
                seg_begin = win_start;
            end
            return;
        end

        span = longint'({32'd0, sample_count}) - longint'({32'd0, seg_begin});
        if (in_segment && span > longint'({32'd0, cur_max_speech}))
        begin
            if (split_end > 0)
            begin
                push_segment(seg_begin, split_end);
                if (split_start < split_end)
                begin
                    in_segment = 1'b0;
                    seg_begin = '0;
                end
                else
                begin
                    seg_begin = split_start;
                end
            end
            else
            begin
                push_segment(seg_begin, sample_count);
                in_segment = 1'b0;
                seg_begin = '0;
            end
            forget_split();
            return;
        end

        if (prob >= floor_q15)
        begin
            return;
        end

        if (in_segment)
        begin
            if (hangover_end == 0)
            begin
                hangover_end = sample_count;
            end
            gap = (sample_count >= hangover_end) ? sample_count - hangover_end : '0;
            if (gap > MAX_SPEECH_SILENCE)
            begin
                split_end = hangover_end;
            end
            if (gap >= cur_min_silence)
            begin
                span = longint'({32'd0, hangover_end}) - longint'({32'd0, seg_begin});
                if (span > longint'({32'd0, cur_min_speech}))
                begin
                    push_segment(seg_begin, hangover_end);
                end
                in_segment = 1'b0;
                seg_begin = '0;
                forget_split();
            end
        end
    endfunction

    function automatic bit [PROB_BITS-1:0] pick_prob(prob_class_t c);
        int floor_q15;
        int top;
        floor_q15 = int'(cur_threshold) - int'(cur_dead_band);
        top = int'(cur_threshold);
        case (c)
            PROB_SPEECH:
                if (top <= int'(PROB_ONE))
                begin
                    return PROB_BITS'($urandom_range(top, int'(PROB_ONE)));
                end
            PROB_DEAD:
                if (top > 0 && floor_q15 < top)
                begin
                    return PROB_BITS'($urandom_range((floor_q15 < 0) ? 0 : floor_q15, top - 1));
                end
            PROB_QUIET:
                if (floor_q15 > 0)
                begin
                    return PROB_BITS'($urandom_range(0, floor_q15 - 1));
                end
            default:
                ;
        endcase
        return PROB_BITS'($urandom_range(0, 2 ** PROB_BITS - 1));
    endfunction

    // The caller is at a falling edge with nothing driven yet in this step.
    task automatic send_item(vst_func_t f, logic [PROB_BITS-1:0] p);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= p;
        predict_item(f, p);
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_windows(prob_class_t c, int count);
        repeat (count) send_item(FUNC_WINDOW, pick_prob(c));
    endtask

    task automatic wait_idle(int extra);
        s_axis_tvalid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (segments_due.size() != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Upper bits of the 16-bit registers carry noise that the block must drop.
    task automatic configure(logic [15:0] thr, logic [15:0] db, logic [31:0] min_sil,
                             logic [31:0] min_sp, logic [31:0] max_sp, logic [15:0] pad_b,
                             logic [15:0] pad_a, logic [31:0] clip);
        wait_idle(SETTLE_CYCLES);
        write_reg(REG_THRESHOLD, {16'($urandom), thr});
        write_reg(REG_DEAD_BAND, {16'($urandom), db});
        write_reg(REG_MIN_SILENCE, min_sil);
        write_reg(REG_MIN_SPEECH, min_sp);
        write_reg(REG_MAX_SPEECH, max_sp);
        write_reg(REG_PAD_BEFORE, {16'($urandom), pad_b});
        write_reg(REG_PAD_AFTER, {16'($urandom), pad_a});
        write_reg(REG_CLIP_LENGTH, clip);
        write_reg(CFG_IDX_BITS'($urandom_range(REG_CLIP_LENGTH + 1, 2 ** CFG_IDX_BITS - 1)),
                  $urandom);
    endtask

    task automatic run_mixed_traffic(int total);
        int sent;
        int roll;
        int len;
        sent = 0;
        while (sent < total)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                len = $urandom_range(1, 14);
                send_windows(PROB_SPEECH, len);
            end
            else if (roll < 78)
            begin
                len = $urandom_range(1, 10);
                send_windows(PROB_QUIET, len);
            end
            else if (roll < 88)
            begin
                len = $urandom_range(1, 4);
                send_windows(PROB_DEAD, len);
            end
            else if (roll < 94)
            begin
                len = $urandom_range(1, 3);
                send_windows(PROB_ANY, len);
            end
            else
            begin
                len = 1;
                send_item(FUNC_END, PROB_BITS'($urandom));
            end
            sent += len;
            if ($urandom_range(0, 29) == 0)
            begin
                wait_idle(0);
            end
        end
    endtask

    task automatic test_directed_cases();
        src_gap_max = 2;
        sink_gap_max = 2;
        send_item(FUNC_END, 16'hFFFF);
        send_item(FUNC_WINDOW, 16'd0);
        send_item(FUNC_WINDOW, 16'd16384);
        send_item(FUNC_END, 16'd0);
        configure(16'd16384, 16'd4915, 32'd1600, 32'd4000, SAMPLE_MAX, 16'd480, 16'd0, 32'd40000);
        send_item(FUNC_WINDOW, 16'd16383);
        send_item(FUNC_WINDOW, 16'd16384 - 16'd4915);
        send_item(FUNC_WINDOW, 16'd16384 - 16'd4916);
        repeat (8) send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_WINDOW, 16'hFFFF);
        repeat (5) send_item(FUNC_WINDOW, 16'd0);
        send_item(FUNC_WINDOW, 16'd16384);
        repeat (2) send_item(FUNC_WINDOW, 16'd0);
        send_item(FUNC_WINDOW, 16'd20000);
        send_item(FUNC_END, 16'h5A5A);
    endtask

    task automatic test_register_extremes();
        src_gap_max = 7;
        sink_gap_max = 7;
        // A dead band wider than the threshold leaves no silence decision.
        configure(16'd1000, 16'd30000, '0, '0, SAMPLE_MAX, 16'd0, 16'd0, SAMPLE_MAX);
        send_item(FUNC_WINDOW, 16'd5000);
        send_item(FUNC_WINDOW, 16'd0);
        repeat (4) send_item(FUNC_WINDOW, 16'd999);
        send_item(FUNC_END, 16'd0);

        configure(16'd0, 16'd0, '0, '0, '0, 16'hFFFF, 16'hFFFF, SAMPLE_MAX);
        send_item(FUNC_WINDOW, 16'd0);
        send_item(FUNC_WINDOW, 16'hFFFF);
        send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_END, 16'hFFFF);

        configure(PROB_ONE, PROB_ONE, SAMPLE_MAX, SAMPLE_MAX, '0, 16'hFFFF, 16'hFFFF, SAMPLE_MAX);
        send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_WINDOW, 16'd0);
        send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_WINDOW, 16'd32767);
        send_item(FUNC_WINDOW, 16'hFFFF);
        send_item(FUNC_END, 16'd0);

        // A short clip puts most of the later speech run past its end.
        configure(PROB_ONE, 16'd0, '0, '0, SAMPLE_MAX, 16'hFFFF, 16'hFFFF, 32'd3000);
        repeat (3) send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_WINDOW, 16'd0);
        repeat (12) send_item(FUNC_WINDOW, PROB_ONE);
        send_item(FUNC_END, 16'd0);
    endtask

    task automatic test_random_segments();
        int          phase;
        logic [15:0] thr;
        logic [15:0] db;
        for (phase = 0; phase < 5; phase++)
        begin
            thr = 16'($urandom_range(6000, 28000));
            db = 16'($urandom_range(0, 8000));
            case (phase)
                0:
                begin
                    configure(thr, db, 32'd1600, 32'd4000, SAMPLE_MAX, 16'd480, 16'd0,
                              $urandom_range(20000, 120000));
                    src_gap_max = 3;
                    sink_gap_max = 0;
                end
                1:
                begin
                    configure(thr, db, $urandom_range(0, 2048), $urandom_range(0, 3000),
                              $urandom_range(1500, 6000), 16'($urandom_range(0, 3000)),
                              16'($urandom_range(0, 3000)), $urandom_range(20000, 120000));
                    src_gap_max = 0;
                    sink_gap_max = 7;
                end
                2:
                begin
                    configure(thr, db, $urandom_range(2600, 7000), $urandom_range(0, 2500),
                              $urandom_range(5000, 12000), 16'($urandom_range(0, 1000)),
                              16'($urandom_range(0, 1000)), $urandom_range(20000, 120000));
                    src_gap_max = 7;
                    sink_gap_max = 3;
                end
                3:
                begin
                    configure(thr, db, $urandom_range(600, 3000), $urandom_range(1000, 6000),
                              $urandom_range(3000, 20000), 16'($urandom),
                              16'($urandom), $urandom_range(20000, 120000));
                    src_gap_max = 7;
                    sink_gap_max = 7;
                end
                default:
                begin
                    configure(thr, db, $urandom_range(0, 1200), '0, $urandom_range(0, 1024),
                              16'd0, 16'($urandom_range(0, 800)), $urandom_range(1000, 60000));
                    src_gap_max = 1;
                    sink_gap_max = 5;
                end
            endcase
            run_mixed_traffic(100);
        end
    endtask

    task automatic test_output_backpressure();
        configure(16'd16384, 16'd0, '0, '0, SAMPLE_MAX, 16'd0, 16'd0, SAMPLE_MAX);
        src_gap_max = 0;
        sink_gap_max = 3;
        @(posedge clk);
        sink_hold_cycles = 200;
        @(negedge clk);
        repeat (40)
        begin
            send_item(FUNC_WINDOW, PROB_ONE);
            send_item(FUNC_WINDOW, 16'd0);
        end
    endtask

    always @(negedge clk)
    begin
        if (sink_hold_cycles != 0)
        begin
            sink_hold_cycles <= sink_hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_segments
        segment_ms_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sink_wait = $urandom_range(0, sink_gap_max);
            if (segments_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected segment, expected none, actual start_ms %0d end_ms %0d",
                         $time, m_axis_tdata[MS_BITS-1:0], m_axis_tdata[2*MS_BITS-1:MS_BITS]);
            end
            else
            begin
                due = segments_due.pop_front();
                if (m_axis_tdata[MS_BITS-1:0] !== due.start_ms)
                begin
                    mismatches++;
                    $display("%0t: start_ms expected %0d actual %0d",
                             $time, due.start_ms, m_axis_tdata[MS_BITS-1:0]);
                end
                if (m_axis_tdata[2*MS_BITS-1:MS_BITS] !== due.end_ms)
                begin
                    mismatches++;
                    $display("%0t: end_ms expected %0d actual %0d",
                             $time, due.end_ms, m_axis_tdata[2*MS_BITS-1:MS_BITS]);
                end
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        restore_defaults();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_register_extremes();
        test_random_segments();
        test_output_backpressure();
        wait_idle(SETTLE_CYCLES);
        if (segments_due.size() == 0 && mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
